FILE: src/btha_pkg.sv
package btha_pkg;

   localparam int HeapBytes   = 4096;
   localparam int HeaderBytes = 8;
   localparam int AlignUnit   = 4;
   localparam int AddrW       = 12;
   localparam int MemDepth    = HeapBytes / AlignUnit;
   localparam int WordW       = $clog2(MemDepth);

   typedef logic [AddrW-1:0] addr_type;
   typedef logic [WordW-1:0] widx_type;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OOM  = 2'd1,
      ST_NOBL = 2'd2,
      ST_WHOLE = 2'd3
   } status_type;

   // header: size (12) | prev (12) | free (1)
   typedef struct packed {
      addr_type size;
      addr_type prev;
      logic     free;
   } hdr_type;

   typedef struct packed {
      logic     wr;
      widx_type waddr;
      hdr_type  wdata;
      widx_type raddr;
   } memreq_type;

   function automatic widx_type word_of(input logic [AddrW:0] byte_off);
      return byte_off[AddrW-1:2];
   endfunction

   function automatic logic [AddrW:0] align_up(input addr_type n);
      logic [AddrW:0] s;
      s = {1'b0, n} + (AddrW+1)'(AlignUnit - 1);
      return {s[AddrW:2], 2'b00};
   endfunction

endpackage

FILE: src/boundary_tag_heap_allocator.sv
// Boundary-tag first-fit heap allocator over a single header RAM (one word per 4 bytes).
// Each chain step issues a header read (S_RD), then uses the registered data (S_WT); a reallocate
// that has to move walks the chain again to allocate, then once more to free the old block.
// Throughput: one word at a time; the next request word is taken once the response leaves.
// Reset: synchronous; the header at offset 0 is written as one free block in state S_INIT
// after reset, block count set to 1, and no request word is taken in that state.
module boundary_tag_heap_allocator
   import btha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  addr_type   req_block_address,
   input  addr_type   req_request_bytes,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output addr_type   rsp_result_address,
   output logic [1:0] rsp_status,
   output logic       rsp_moved,
   output addr_type   rsp_copy_bytes
);

   typedef enum logic [14:0] {
      S_INIT  = 15'h0001,
      S_IDLE  = 15'h0002,
      S_RD    = 15'h0004,  // issue read of cur
      S_WT    = 15'h0008,  // header of cur arrives
      S_NRD   = 15'h0010,  // issue read of next(h)
      S_NWT   = 15'h0020,
      S_DEC   = 15'h0040,  // decide free/realloc action
      S_W1    = 15'h0080,  // write primary header
      S_W2    = 15'h0100,  // write split header
      S_FRD   = 15'h0200,  // read follower
      S_FWT   = 15'h0400,
      S_FW    = 15'h0800,  // write follower prev
      S_RESP  = 15'h1000,
      S_FREE2 = 15'h2000,  // start free of old block after realloc move
      S_PFX   = 15'h4000   // hand over to the response or the pending free
   } state_type;

   typedef enum logic [1:0] {
      M_ALLOC = 2'd0,
      M_FIND  = 2'd1
   } mode_type;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [1:0]  cmd_ff, cmd_in;
   addr_type    addr_ff, addr_in;
   logic [AddrW:0] need_ff, need_in;
   logic [WordW-1:0] cnt_ff, cnt_in;   // block count
   logic [WordW:0]   i_ff, i_in;       // walk index
   logic [AddrW:0]   cur_ff, cur_in;
   logic [AddrW:0]   p_ff, p_in;
   logic             hp_ff, hp_in;
   hdr_type          ph_ff, ph_in;     // header of previous block
   hdr_type          h_ff, h_in;       // header of target
   logic [AddrW:0]   hoff_ff, hoff_in;
   hdr_type          n_ff, n_in;
   logic             nval_ff, nval_in; // next exists
   // pending writes
   logic [AddrW:0]   w1off_ff, w1off_in;
   hdr_type          w1_ff, w1_in;
   logic             w2en_ff, w2en_in;
   logic [AddrW:0]   w2off_ff, w2off_in;
   hdr_type          w2_ff, w2_in;
   logic             fen_ff, fen_in;   // follower fix pending
   logic [AddrW:0]   foff_ff, foff_in;
   addr_type         fprev_ff, fprev_in;
   logic             fr2_ff, fr2_in;   // free old block after move
   // response
   logic             rv_ff, rv_in;
   addr_type         res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic             mv_ff, mv_in;
   addr_type         cp_ff, cp_in;

   memreq_type mreq;
   hdr_type    rdata;

   btha_hdr_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   logic [AddrW+1:0] nxt_cur;   // next_of(cur) using rdata
   logic [AddrW+1:0] need_sum, wpn, wp, wn;
   logic             pf, nf;

   always_comb begin
      logic [AddrW+1:0] noff;
      state_in = state_ff; mode_in = mode_ff; cmd_in = cmd_ff; addr_in = addr_ff;
      need_in = need_ff; cnt_in = cnt_ff; i_in = i_ff; cur_in = cur_ff; p_in = p_ff;
      hp_in = hp_ff; ph_in = ph_ff; h_in = h_ff; hoff_in = hoff_ff; n_in = n_ff;
      nval_in = nval_ff; w1off_in = w1off_ff; w1_in = w1_ff; w2en_in = w2en_ff;
      w2off_in = w2off_ff; w2_in = w2_ff; fen_in = fen_ff; foff_in = foff_ff;
      fprev_in = fprev_ff; fr2_in = fr2_ff;
      rv_in = rv_ff; res_in = res_ff; st_in = st_ff; mv_in = mv_ff; cp_in = cp_ff;
      mreq = '0;
      nxt_cur = {1'b0, cur_ff} + (AddrW+2)'(HeaderBytes) + {2'b0, rdata.size};
      noff = '0;
      pf = hp_ff && ph_ff.free;
      nf = nval_ff && n_ff.free;
      wpn = {2'b0, ph_ff.size} + {2'b0, h_ff.size} + {2'b0, n_ff.size}
            + (AddrW+2)'(2 * HeaderBytes);
      wp  = {2'b0, ph_ff.size} + {2'b0, h_ff.size} + (AddrW+2)'(HeaderBytes);
      wn  = {2'b0, h_ff.size} + {2'b0, n_ff.size} + (AddrW+2)'(HeaderBytes);
      need_sum = {1'b0, need_ff};
      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            mreq.wr = 1'b1;
            mreq.waddr = '0;
            mreq.wdata = '{size: addr_type'(HeapBytes - HeaderBytes), prev: '0, free: 1'b1};
            cnt_in = WordW'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               cmd_in = req_command; addr_in = req_block_address;
               need_in = align_up(req_request_bytes);
               res_in = '0; st_in = ST_OK; mv_in = 1'b0; cp_in = '0;
               i_in = '0; cur_in = '0; hp_in = 1'b0; p_in = '0;
               fen_in = 1'b0; w2en_in = 1'b0; fr2_in = 1'b0;
               priority if (req_command == CMD_NONE) begin
                  rv_in = 1'b1;
               end else if (req_command == CMD_ALLOC ||
                            (req_command == CMD_REALLOC && req_block_address == '0)) begin
                  mode_in = M_ALLOC; state_in = S_RD;
               end else begin
                  mode_in = M_FIND; state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (i_ff >= {1'b0, cnt_ff} || cur_ff[AddrW]) begin
               if (mode_ff == M_ALLOC) begin
                  st_in = ST_OOM; res_in = '0;
                  if (fr2_ff) begin mv_in = 1'b0; cp_in = '0; end
                  fr2_in = 1'b0;
               end else st_in = ST_NOBL;
               state_in = S_RESP;
            end else begin
               mreq.raddr = word_of(cur_ff);
               state_in = S_WT;
            end
         end
         S_WT: begin
            if (mode_ff == M_ALLOC) begin
               if (rdata.free && {1'b0, rdata.size} >= need_ff) begin
                  hoff_in = cur_ff;
                  res_in = addr_type'(cur_ff + (AddrW+1)'(HeaderBytes));
                  w1off_in = cur_ff;
                  w1_in = rdata; w1_in.free = 1'b0;
                  // settle(cur, need, size)
                  if ({2'b0, rdata.size} - {1'b0, need_ff} > (AddrW+2)'(HeaderBytes)) begin
                     noff = {1'b0, cur_ff} + (AddrW+2)'(HeaderBytes) + {1'b0, need_ff};
                     w1_in.size = addr_type'(need_ff);
                     w2en_in = 1'b1;
                     w2off_in = noff[AddrW:0];
                     w2_in = '{size: addr_type'({1'b0, rdata.size} - need_ff
                                               - (AddrW+1)'(HeaderBytes)),
                               prev: addr_type'(need_ff), free: 1'b1};
                     cnt_in = cnt_ff + WordW'(1);
                     noff = {1'b0, noff[AddrW:0]} + (AddrW+2)'(HeaderBytes)
                            + {2'b0, w2_in.size};
                     foff_in = noff[AddrW:0];
                     fen_in = !noff[AddrW+1] && !noff[AddrW];
                     fprev_in = w2_in.size;
                  end else begin
                     noff = nxt_cur;
                     foff_in = noff[AddrW:0];
                     fen_in = !noff[AddrW+1] && !noff[AddrW];
                     fprev_in = rdata.size;
                  end
                  state_in = S_W1;
               end else begin
                  i_in = i_ff + (WordW+1)'(1);
                  cur_in = nxt_cur[AddrW+1] ? {1'b1, {AddrW{1'b0}}} : nxt_cur[AddrW:0];
                  state_in = S_RD;
               end
            end else begin
               if (cur_ff + (AddrW+1)'(HeaderBytes) == {1'b0, addr_ff}) begin
                  h_in = rdata; hoff_in = cur_ff;
                  if (rdata.free) begin
                     st_in = ST_NOBL; state_in = S_RESP;
                  end else begin
                     state_in = S_NRD;
                  end
               end else begin
                  ph_in = rdata; p_in = cur_ff; hp_in = 1'b1;
                  i_in = i_ff + (WordW+1)'(1);
                  cur_in = nxt_cur[AddrW+1] ? {1'b1, {AddrW{1'b0}}} : nxt_cur[AddrW:0];
                  state_in = S_RD;
               end
               // wholly free check: first header, only block, free
               if (i_ff == '0 && cnt_ff == WordW'(1) && rdata.free && addr_ff != '0) begin
                  st_in = ST_WHOLE; state_in = S_RESP;
               end
            end
         end
         S_NRD: begin
            noff = {1'b0, hoff_ff} + (AddrW+2)'(HeaderBytes) + {2'b0, h_ff.size};
            nval_in = !noff[AddrW+1] && !noff[AddrW];
            cur_in = noff[AddrW:0];
            mreq.raddr = word_of(noff[AddrW:0]);
            state_in = S_NWT;
         end
         S_NWT: begin
            n_in = rdata;
            state_in = S_DEC;
         end
         S_DEC: begin
            w2en_in = 1'b0; fen_in = 1'b0;
            if (cmd_ff == CMD_FREE) begin
               w1off_in = hoff_ff; w1_in = h_ff; w1_in.free = 1'b1;
               if (nf) begin
                  w1_in.size = addr_type'(wn);
                  cnt_in = cnt_ff - WordW'(1);
               end
               if (pf) begin
                  w1off_in = p_ff; w1_in = ph_ff;
                  w1_in.size = nf ? addr_type'(wpn) : addr_type'(wp);
                  cnt_in = cnt_ff - (nf ? WordW'(2) : WordW'(1));
               end
               noff = {1'b0, w1off_in} + (AddrW+2)'(HeaderBytes) + {2'b0, w1_in.size};
               foff_in = noff[AddrW:0];
               fen_in = !noff[AddrW+1] && !noff[AddrW];
               fprev_in = w1_in.size;
               state_in = S_W1;
            end else begin
               // realloc
               logic [AddrW+1:0] tot;
               logic [AddrW:0]   base;
               logic             go;
               tot = '0; base = hoff_ff; go = 1'b1;
               priority if (need_ff == {1'b0, h_ff.size}) begin
                  res_in = addr_ff; go = 1'b0; state_in = S_RESP;
               end else if (need_ff < {1'b0, h_ff.size}) begin
                  tot = {2'b0, h_ff.size}; res_in = addr_ff;
               end else if ((pf && nf && wpn > need_sum) || (pf && wp > need_sum)) begin
                  tot = (pf && nf && wpn > need_sum) ? wpn : wp;
                  cnt_in = cnt_ff - ((pf && nf && wpn > need_sum) ? WordW'(2) : WordW'(1));
                  base = p_ff;
                  res_in = addr_type'(p_ff + (AddrW+1)'(HeaderBytes));
                  mv_in = 1'b1; cp_in = h_ff.size;
               end else if (nf && wn > need_sum) begin
                  tot = wn; cnt_in = cnt_ff - WordW'(1); res_in = addr_ff;
               end else begin
                  // allocate elsewhere, then free old block
                  go = 1'b0;
                  mode_in = M_ALLOC; i_in = '0; cur_in = '0;
                  fr2_in = 1'b1; mv_in = 1'b1; cp_in = h_ff.size;
                  state_in = S_RD;
               end
               if (go) begin
                  w1off_in = base;
                  w1_in = (base == hoff_ff) ? h_ff : ph_ff;
                  w1_in.free = 1'b0;
                  if (tot - need_sum > (AddrW+2)'(HeaderBytes)) begin
                     noff = {1'b0, base} + (AddrW+2)'(HeaderBytes) + need_sum;
                     w1_in.size = addr_type'(need_ff);
                     w2en_in = !noff[AddrW+1] && !noff[AddrW];
                     w2off_in = noff[AddrW:0];
                     w2_in = '{size: addr_type'(tot - need_sum - (AddrW+2)'(HeaderBytes)),
                               prev: addr_type'(need_ff), free: 1'b1};
                     if (w2en_in) cnt_in = cnt_in + WordW'(1);
                     noff = noff + (AddrW+2)'(HeaderBytes) + {2'b0, w2_in.size};
                     foff_in = noff[AddrW:0];
                     fen_in = w2en_in && !noff[AddrW+1] && !noff[AddrW];
                     fprev_in = w2_in.size;
                  end else begin
                     w1_in.size = addr_type'(tot);
                     noff = {1'b0, base} + (AddrW+2)'(HeaderBytes) + tot;
                     foff_in = noff[AddrW:0];
                     fen_in = !noff[AddrW+1] && !noff[AddrW];
                     fprev_in = w1_in.size;
                  end
                  state_in = S_W1;
               end
            end
         end
         S_W1: begin
            mreq.wr = 1'b1; mreq.waddr = word_of(w1off_ff); mreq.wdata = w1_ff;
            state_in = w2en_ff ? S_W2 : (fen_ff ? S_FRD : S_PFX);
         end
         S_W2: begin
            mreq.wr = 1'b1; mreq.waddr = word_of(w2off_ff); mreq.wdata = w2_ff;
            state_in = fen_ff ? S_FRD : S_PFX;
         end
         S_FRD: begin
            mreq.raddr = word_of(foff_ff);
            state_in = S_FWT;
         end
         S_FWT: begin
            n_in = rdata; n_in.prev = fprev_ff;
            state_in = S_FW;
         end
         S_FW: begin
            mreq.wr = 1'b1; mreq.waddr = word_of(foff_ff); mreq.wdata = n_ff;
            state_in = S_PFX;
         end
         S_PFX: begin
            state_in = fr2_ff ? S_FREE2 : S_RESP;
         end
         S_FREE2: begin
            // free the old block: restart a find walk with command free
            fr2_in = 1'b0; cmd_in = CMD_FREE; mode_in = M_FIND;
            i_in = '0; cur_in = '0; hp_in = 1'b0; p_in = '0;
            w2en_in = 1'b0; fen_in = 1'b0;
            state_in = S_RD;
         end
         S_RESP: begin
            if (!rv_ff) begin
               if (st_ff != ST_OK) begin
                  res_in = '0;
                  if (st_ff != ST_OOM || cmd_ff != CMD_REALLOC) begin
                     mv_in = 1'b0; cp_in = '0;
                  end
               end
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; rv_ff <= 1'b0; cnt_ff <= WordW'(1); mode_ff <= M_ALLOC;
         fr2_ff <= 1'b0; fen_ff <= 1'b0; w2en_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; cnt_ff <= cnt_in; mode_ff <= mode_in;
         fr2_ff <= fr2_in; fen_ff <= fen_in; w2en_ff <= w2en_in;
      end
      cmd_ff <= cmd_in; addr_ff <= addr_in; need_ff <= need_in; i_ff <= i_in;
      cur_ff <= cur_in; p_ff <= p_in; hp_ff <= hp_in; ph_ff <= ph_in; h_ff <= h_in;
      hoff_ff <= hoff_in; n_ff <= n_in; nval_ff <= nval_in; w1off_ff <= w1off_in;
      w1_ff <= w1_in; w2off_ff <= w2off_in; w2_ff <= w2_in; foff_ff <= foff_in;
      fprev_ff <= fprev_in; res_ff <= res_in; st_ff <= st_in; mv_ff <= mv_in;
      cp_ff <= cp_in;
   end

   assign req_stall = !(state_ff == S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_result_address = res_ff;
   assign rsp_status = st_ff;
   assign rsp_moved = mv_ff;
   assign rsp_copy_bytes = cp_ff;

   // Hold a pending response until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff) else $error("response dropped");
   // Take no word while a response waits.
   a_nostack: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall) else $error("request taken over pending response");
   // Block count is never zero in the idle state.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cnt_ff != '0) else $error("empty chain");

endmodule

FILE: src/btha_hdr_ram.sv
module btha_hdr_ram
   import btha_pkg::*;
(
   input  logic       clock,
   input  memreq_type req,
   output hdr_type    rdata
);

   hdr_type mem [MemDepth];

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata <= mem[req.raddr];
   end

endmodule

FILE: test/tb_top.sv
module tb_top
   import btha_pkg::*;
();

   // one result word as the testbench sees it
   typedef struct packed {
      addr_type   res;
      logic [1:0] st;
      logic       mv;
      addr_type   cp;
   } heap_rsp_type;

   // directed stimulus row; chk marks rows whose answer is typed in here
   typedef struct packed {
      cmd_type      cmd;
      int           addr;
      int           req;
      bit           chk;
      heap_rsp_type want;
   } heap_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_ALLOC;
   addr_type   req_block_address = '0;
   addr_type   req_request_bytes = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   addr_type   rsp_result_address;
   logic [1:0] rsp_status;
   logic       rsp_moved;
   addr_type   rsp_copy_bytes;

   boundary_tag_heap_allocator DUT (.*);

   // 10 time unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Heap shadow: one header per byte offset, plus the chain length
   // ---------------------------------------------------------------
   int hsize [HeapBytes];
   int hprev [HeapBytes];
   bit hfree [HeapBytes];
   int nblocks;

   heap_rsp_type pending_rsp[$];
   bit        live[int];      // payload addresses currently allocated
   int        errors = 0;
   int        n_sent = 0;
   int        n_seen = 0;
   int        n_cmd[4] = '{0, 0, 0, 0};
   int        n_st[4] = '{0, 0, 0, 0};
   int        n_moved = 0;
   bit        quiet = 1'b0;   // phases with no idling at all

   function automatic int round4(int n);
      return (n + AlignUnit - 1) / AlignUnit * AlignUnit;
   endfunction

   function automatic int next_hdr(int h);
      return h + HeaderBytes + hsize[h];
   endfunction

   // refresh the previous-size mark of the block after h, if any
   function automatic void mark_follower(int h);
      int n;
      n = next_hdr(h);
      if (n < HeapBytes) hprev[n] = hsize[h];
   endfunction

   // give block h a payload of need out of total, splitting when worthwhile
   function automatic void carve(int h, int need, int total);
      int n;
      if (total - need > HeaderBytes) begin
         n = h + HeaderBytes + need;
         hsize[h] = need;
         if (n < HeapBytes) begin
            hsize[n] = total - need - HeaderBytes;
            hprev[n] = need;
            hfree[n] = 1'b1;
            nblocks++;
            mark_follower(n);
         end
      end else begin
         hsize[h] = total;
         mark_follower(h);
      end
   endfunction

   function automatic bit heap_empty();
      return nblocks == 1 && hfree[0];
   endfunction

   function automatic bit locate(int addr, output int h, output bit hp, output int ph);
      int cur, p;
      bit has_p;
      cur = 0; p = 0; has_p = 1'b0; h = 0; hp = 1'b0; ph = 0;
      for (int i = 0; i < nblocks && cur < HeapBytes; i++) begin
         if (cur + HeaderBytes == addr) begin
            h = cur; hp = has_p; ph = p;
            return 1'b1;
         end
         p = cur;
         has_p = 1'b1;
         cur = next_hdr(cur);
      end
      return 1'b0;
   endfunction

   function automatic int first_fit(int req, output int addr);
      int need, cur;
      need = round4(req);
      cur = 0;
      for (int i = 0; i < nblocks && cur < HeapBytes; i++) begin
         if (hfree[cur] && hsize[cur] >= need) begin
            hfree[cur] = 1'b0;
            carve(cur, need, hsize[cur]);
            addr = cur + HeaderBytes;
            return ST_OK;
         end
         cur = next_hdr(cur);
      end
      addr = 0;
      return ST_OOM;
   endfunction

   function automatic int release_blk(int addr);
      int h, ph, n;
      bit hp;
      if (addr != 0 && heap_empty()) return ST_WHOLE;
      if (!locate(addr, h, hp, ph) || hfree[h]) return ST_NOBL;
      hfree[h] = 1'b1;
      n = next_hdr(h);
      if (n < HeapBytes && hfree[n]) begin
         hsize[h] += HeaderBytes + hsize[n];
         nblocks--;
      end
      if (hp && hfree[ph]) begin
         hsize[ph] += HeaderBytes + hsize[h];
         nblocks--;
         h = ph;
      end
      mark_follower(h);
      return ST_OK;
   endfunction

   // work out the answer to one request word and advance the shadow heap
   function automatic heap_rsp_type heap_predict(logic [1:0] cmd, int addr, int req);
      heap_rsp_type r;
      int res, st, mv, cp, h, ph, n, sz, need, psz, nsz, wpn, wp, wn;
      bit hp, pf, nf;
      res = 0; st = ST_OK; mv = 0; cp = 0;
      case (cmd)
         CMD_ALLOC: st = first_fit(req, res);
         CMD_FREE:  st = release_blk(addr);
         CMD_REALLOC: begin
            if (addr == 0) st = first_fit(req, res);
            else if (heap_empty()) st = ST_WHOLE;
            else if (!locate(addr, h, hp, ph) || hfree[h]) st = ST_NOBL;
            else begin
               sz = hsize[h];
               need = round4(req);
               n = next_hdr(h);
               if (need == sz) res = addr;
               else if (need < sz) begin
                  carve(h, need, sz);
                  res = addr;
               end else begin
                  pf = hp && hfree[ph];
                  nf = n < HeapBytes && hfree[n];
                  psz = pf ? hsize[ph] : 0;
                  nsz = nf ? hsize[n] : 0;
                  wpn = (pf && nf) ? psz + sz + nsz + 2 * HeaderBytes : 0;
                  wp = pf ? psz + sz + HeaderBytes : 0;
                  wn = nf ? sz + nsz + HeaderBytes : 0;
                  if (wpn > need || wp > need) begin
                     nblocks -= (wpn > need) ? 2 : 1;
                     hfree[ph] = 1'b0;
                     carve(ph, need, (wpn > need) ? wpn : wp);
                     res = ph + HeaderBytes;
                     mv = 1; cp = sz;
                  end else if (wn > need) begin
                     nblocks--;
                     carve(h, need, wn);
                     res = addr;
                  end else begin
                     st = first_fit(need, res);
                     if (st == ST_OK) begin
                        void'(release_blk(addr));
                        mv = 1; cp = sz;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.res = addr_type'(res);
      r.st = st[1:0];
      r.mv = mv[0];
      r.cp = addr_type'(cp);
      return r;
   endfunction

   // mostly short gaps, a few long ones, none during quiet phases
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------
   // Request side: drive one word, hold it until taken, then predict
   // ---------------------------------------------------------------
   task automatic send_word(cmd_type cmd, int addr, int req, bit chk, heap_rsp_type want);
      heap_rsp_type p;
      int g;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_block_address <= addr_type'(addr);
      req_request_bytes <= addr_type'(req);
      do @(posedge clock); while (!(req_valid && !req_stall));
      p = heap_predict(cmd, addr & 12'hFFF, req & 12'hFFF);
      pending_rsp.push_back(chk ? want : p);
      n_sent++;
      n_cmd[cmd]++;
      // keep the list of live blocks in step with the heap
      if (p.st == ST_OK) begin
         if (cmd == CMD_FREE) live.delete(addr);
         if (cmd == CMD_REALLOC && addr != 0 && int'(p.res) != addr) live.delete(addr);
         if (cmd != CMD_FREE && p.res != 0) live[int'(p.res)] = 1'b1;
      end
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic int pick_live();
      int keys[$];
      foreach (live[k]) keys.push_back(k);
      if (keys.size() == 0) return $urandom_range(0, 4095);
      return keys[$urandom_range(0, keys.size() - 1)];
   endfunction

   function automatic int pick_size();
      if ($urandom_range(0, 99) < 90) return $urandom_range(0, 96);
      return $urandom_range(0, 4095);
   endfunction

   // ---------------------------------------------------------------
   // Result side: random stall, compare each taken word with the oldest
   // ---------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      heap_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_seen++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word: addr %0d status %0d",
                                       rsp_result_address, rsp_status);
         end else begin
            w = pending_rsp.pop_front();
            n_st[w.st]++;
            if (w.mv) n_moved++;
            if (rsp_result_address !== w.res || rsp_status !== w.st ||
                rsp_moved !== w.mv || rsp_copy_bytes !== w.cp) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch word %0d: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           n_seen, w.res, w.st, w.mv, w.cp, rsp_result_address,
                           rsp_status, rsp_moved, rsp_copy_bytes);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Directed table: typed answers after reset and at the extremes only
   // ---------------------------------------------------------------
   localparam heap_rsp_type NONE = '{12'd0, ST_OK, 1'b0, 12'd0};
   localparam heap_row_type ROWS[22] = '{
      '{CMD_FREE,    8,    0,    1'b1, '{12'd0, ST_WHOLE, 1'b0, 12'd0}},
      '{CMD_REALLOC, 8,    16,   1'b1, '{12'd0, ST_WHOLE, 1'b0, 12'd0}},
      '{CMD_NONE,    4095, 4095, 1'b1, NONE},
      '{CMD_ALLOC,   0,    4095, 1'b1, '{12'd0, ST_OOM, 1'b0, 12'd0}},
      '{CMD_ALLOC,   0,    4088, 1'b1, '{12'd8, ST_OK, 1'b0, 12'd0}},
      '{CMD_FREE,    100,  0,    1'b1, '{12'd0, ST_NOBL, 1'b0, 12'd0}},
      '{CMD_FREE,    8,    0,    1'b1, NONE},
      '{CMD_ALLOC,   0,    0,    1'b0, NONE},
      '{CMD_ALLOC,   0,    13,   1'b0, NONE},
      '{CMD_ALLOC,   0,    16,   1'b0, NONE},
      '{CMD_ALLOC,   0,    16,   1'b0, NONE},
      '{CMD_ALLOC,   0,    20,   1'b0, NONE},
      '{CMD_FREE,    16,   0,    1'b0, NONE},
      '{CMD_FREE,    16,   0,    1'b0, NONE},
      '{CMD_REALLOC, 40,   64,   1'b0, NONE},
      '{CMD_REALLOC, 0,    12,   1'b0, NONE},
      '{CMD_REALLOC, 16,   16,   1'b0, NONE},
      '{CMD_REALLOC, 16,   4,    1'b0, NONE},
      '{CMD_REALLOC, 16,   400,  1'b0, NONE},
      '{CMD_REALLOC, 16,   4095, 1'b0, NONE},
      '{CMD_FREE,    0,    0,    1'b0, NONE},
      '{CMD_FREE,    4095, 4095, 1'b0, NONE}
   };

   initial begin
      int r, a, c;
      nblocks = 1;
      hsize[0] = HeapBytes - HeaderBytes;
      hfree[0] = 1'b1;
      // hold reset, then release it on a clock edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (ROWS[i])
         send_word(ROWS[i].cmd, ROWS[i].addr, ROWS[i].req, ROWS[i].chk, ROWS[i].want);

      // random part: mostly well-formed traffic on live blocks, some noise
      for (int i = 0; i < 800; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (live.num() > 40 && r < 45) r = 50;
         if (live.num() == 0 && r >= 45) r = 10;
         if (r < 5) begin
            c = $urandom_range(0, 3);
            send_word(cmd_type'(c), $urandom_range(0, 4095), $urandom_range(0, 4095),
                      1'b0, NONE);
         end else if (r < 45) begin
            send_word(CMD_ALLOC, $urandom_range(0, 4095), pick_size(), 1'b0, NONE);
         end else if (r < 75) begin
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : pick_live();
            send_word(CMD_FREE, a, $urandom_range(0, 4095), 1'b0, NONE);
         end else begin
            a = ($urandom_range(0, 9) == 0) ? 0 : pick_live();
            send_word(CMD_REALLOC, a, pick_size(), 1'b0, NONE);
         end
      end
      req_valid <= 1'b0;

      // drain, then let the block settle
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d words: %0d alloc, %0d free, %0d realloc, %0d unused",
               n_sent, n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3]);
      $display("answers: %0d ok, %0d no room, %0d unknown block, %0d empty heap, %0d moved",
               n_st[0], n_st[1], n_st[2], n_st[3], n_moved);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #150000000;
      $display("timeout with %0d words outstanding", pending_rsp.size());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
